// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DFE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dfe assertion failed");

// Checked on every clock edge, reset included.
`define DFE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dfe reset assertion failed");

`endif

// File: rtl/core/dfe_pkg.sv
// ---------------------------------------------------------------------------
// dfe_pkg
// Types and constants of the delimited field extractor.
// ---------------------------------------------------------------------------
package dfe_pkg;

    localparam int DELIM_LIMIT = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_NUMBER    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_CHARS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_COUNT = 2'd2;

    localparam logic [7:0]  RST_FIELD_NUMBER    = 8'd0;
    localparam logic [63:0] RST_DELIMITER_CHARS = 64'd32;
    localparam logic [3:0]  RST_DELIMITER_COUNT = 4'd1;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [7:0] field_char;
        logic       char_valid;
        logic       line_done;
        logic       field_found;
    } t_out;

    typedef struct packed {
        logic [7:0]  field_number;
        logic [63:0] delimiter_chars;
        logic [3:0]  delimiter_count;
    } t_cfg;

endpackage

// File: rtl/core/dfe_cfg_regs.sv
// ---------------------------------------------------------------------------
// dfe_cfg_regs
// Configuration registers written through the plain write port.
// ---------------------------------------------------------------------------
module dfe_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dfe_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [dfe_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output dfe_pkg::t_cfg                    o_cfg
);

    dfe_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_number    <= dfe_pkg::RST_FIELD_NUMBER;
            r_cfg.delimiter_chars <= dfe_pkg::RST_DELIMITER_CHARS;
            r_cfg.delimiter_count <= dfe_pkg::RST_DELIMITER_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dfe_pkg::CFG_FIELD_NUMBER: begin
                    r_cfg.field_number <= i_cfg_wdata[7:0];
                end
                dfe_pkg::CFG_DELIMITER_CHARS: begin
                    r_cfg.delimiter_chars <= i_cfg_wdata[63:0];
                end
                dfe_pkg::CFG_DELIMITER_COUNT: begin
                    r_cfg.delimiter_count <= i_cfg_wdata[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/dfe_delim_match.sv
// ---------------------------------------------------------------------------
// dfe_delim_match
// Parallel compare of one character against the active delimiter bytes.
// ---------------------------------------------------------------------------
module dfe_delim_match #(
    parameter int MAX_DELIMITERS = dfe_pkg::DELIM_LIMIT
) (
    input  dfe_pkg::t_cfg i_cfg,
    input  logic [7:0]    i_char,
    output logic          o_is_delim
);

    logic [3:0]                lim;
    logic [MAX_DELIMITERS-1:0] hit;

    always_comb begin
        if (i_cfg.delimiter_count > 4'(MAX_DELIMITERS)) begin
            lim = 4'(MAX_DELIMITERS);
        end else begin
            lim = i_cfg.delimiter_count;
        end
        for (int k = 0; k < MAX_DELIMITERS; k++) begin
            hit[k] = (4'(k) < lim) && (i_cfg.delimiter_chars[8*k +: 8] == i_char);
        end
    end

    assign o_is_delim = |hit;

endmodule

// File: rtl/core/dfe_tokenizer.sv
// ---------------------------------------------------------------------------
// dfe_tokenizer
// Field tracking state machine and result register.
// ---------------------------------------------------------------------------
module dfe_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dfe_pkg::t_in  i_data,
    input  logic          i_is_delim,
    input  logic [7:0]    i_field_number,
    output logic          o_go,
    output logic          o_valid,
    output dfe_pkg::t_out o_data,
    input  logic          i_stall
);

    localparam logic [1:0] PH_SEEKING  = 2'd0;
    localparam logic [1:0] PH_IN_FIELD = 2'd1;
    localparam logic [1:0] PH_DONE     = 2'd2;

    logic [1:0]    r_phase,   n_phase;
    logic [7:0]    r_runs,    n_runs;
    logic          r_in_run,  n_in_run;
    logic          r_emitted, n_emitted;
    logic          r_out_valid;
    dfe_pkg::t_out r_out;

    logic emit;
    logic produce;
    logic out_free;
    logic at_field;

    assign at_field = (r_runs == i_field_number);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_phase  = r_phase;
        n_runs   = r_runs;
        n_in_run = r_in_run;
        emit     = 1'b0;
        unique case (r_phase)
            PH_SEEKING: begin
                if (i_is_delim) begin
                    if (!r_in_run) begin
                        if (at_field) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_runs   = r_runs + 8'd1;
                            n_in_run = 1'b1;
                        end
                    end
                end else begin
                    n_in_run = 1'b0;
                    if (at_field) begin
                        n_phase = PH_IN_FIELD;
                        emit    = 1'b1;
                    end
                end
            end
            PH_IN_FIELD: begin
                if (i_is_delim) begin
                    n_phase = PH_DONE;
                end else begin
                    emit = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_emitted = r_emitted || emit;
        if (i_data.last) begin
            n_phase   = PH_SEEKING;
            n_runs    = 8'd0;
            n_in_run  = 1'b0;
            n_emitted = 1'b0;
        end
    end

    assign produce = emit || i_data.last;
    assign o_go    = i_valid && (!produce || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEEKING;
            r_runs      <= 8'd0;
            r_in_run    <= 1'b0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_go) begin
                r_phase   <= n_phase;
                r_runs    <= n_runs;
                r_in_run  <= n_in_run;
                r_emitted <= n_emitted;
            end
            if (out_free) begin
                r_out_valid <= o_go && produce;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && o_go && produce) begin
            r_out.field_char  <= emit ? i_data.char_in : 8'd0;
            r_out.char_valid  <= emit;
            r_out.line_done   <= i_data.last;
            r_out.field_found <= i_data.last && (r_emitted || emit);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: rtl/core/delimited_field_extract.sv
// ---------------------------------------------------------------------------
// delimited_field_extract: one character per cycle while o_stall is low; a result is
// valid once its transaction has passed the input register, then the result register.
// Throughput is set by the field state update.
// Synchronous active-low reset clears control state and restores the config defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module delimited_field_extract #(
    parameter int MAX_DELIMITERS = dfe_pkg::DELIM_LIMIT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dfe_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [dfe_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_valid,
    input  dfe_pkg::t_in                     i_data,
    output logic                             o_stall,
    output logic                             o_valid,
    output dfe_pkg::t_out                    o_data,
    input  logic                             i_stall
);

    dfe_pkg::t_cfg cfg;
    dfe_pkg::t_in  r_in;
    logic          r_in_valid;
    logic          is_delim;
    logic          go;
    logic          accept;

    dfe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign o_stall = r_in_valid && !go;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
    end

    dfe_delim_match #(
        .MAX_DELIMITERS (MAX_DELIMITERS)
    ) u_match (
        .i_cfg      (cfg),
        .i_char     (r_in.char_in),
        .o_is_delim (is_delim)
    );

    dfe_tokenizer u_tok (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_in_valid),
        .i_data         (r_in),
        .i_is_delim     (is_delim),
        .i_field_number (cfg.field_number),
        .o_go           (go),
        .o_valid        (o_valid),
        .o_data         (o_data),
        .i_stall        (i_stall)
    );

    `DFE_ASSERT(a_result_has_cause, o_valid |-> (o_data.char_valid || o_data.line_done))
    `DFE_ASSERT(a_found_at_end, (o_valid && o_data.field_found) |-> o_data.line_done)
    `DFE_ASSERT(a_char_zero_idle, (o_valid && !o_data.char_valid) |-> (o_data.field_char == 8'd0))
    `DFE_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!o_valid && !o_stall))

endmodule

// File: tb/dfe_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dfe_checker
// Watches the configuration port and both streaming channels of the field
// extractor, tracks the line scan per accepted character and compares
// every accepted output transaction with the oldest predicted one.
// ---------------------------------------------------------------------------
module dfe_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dfe_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dfe_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    input  dfe_pkg::t_in                    i_in_data,
    input  logic                            i_in_stall,
    input  logic                            i_out_valid,
    input  dfe_pkg::t_out                   i_out_data,
    input  logic                            i_out_stall,
    output int                              o_errors,
    output int                              o_pending
);

    typedef enum logic [1:0] {
        SCAN_SEEK  = 2'd0,
        SCAN_FIELD = 2'd1,
        SCAN_DONE  = 2'd2
    } t_scan_phase;

    dfe_pkg::t_cfg regs;
    t_scan_phase   phase;
    logic [7:0]    runs;
    logic          in_run;
    logic          emitted;
    dfe_pkg::t_out field_q[$];
    int            errors = 0;

    function automatic logic is_sep(input logic [7:0] c);
        int   n;
        logic hit;
        n   = (regs.delimiter_count > dfe_pkg::DELIM_LIMIT) ? dfe_pkg::DELIM_LIMIT
                                                           : int'(regs.delimiter_count);
        hit = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (regs.delimiter_chars[8*k +: 8] == c) hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic scan_char(input dfe_pkg::t_in item);
        logic          sep;
        logic          emit;
        dfe_pkg::t_out res;
        sep  = is_sep(item.char_in);
        emit = 1'b0;
        case (phase)
            SCAN_SEEK: begin
                if (sep) begin
                    if (!in_run) begin
                        if (runs == regs.field_number) begin
                            phase = SCAN_DONE;
                        end else begin
                            runs   = runs + 8'd1;
                            in_run = 1'b1;
                        end
                    end
                end else begin
                    in_run = 1'b0;
                    if (runs == regs.field_number) begin
                        phase = SCAN_FIELD;
                        emit  = 1'b1;
                    end
                end
            end
            SCAN_FIELD: begin
                if (sep) phase = SCAN_DONE;
                else emit = 1'b1;
            end
            default: ;
        endcase
        if (emit) emitted = 1'b1;
        if (emit || item.last) begin
            res.field_char  = emit ? item.char_in : 8'd0;
            res.char_valid  = emit;
            res.line_done   = item.last;
            res.field_found = item.last && emitted;
            field_q.push_back(res);
        end
        if (item.last) begin
            phase   = SCAN_SEEK;
            runs    = 8'd0;
            in_run  = 1'b0;
            emitted = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        dfe_pkg::t_out want;
        dfe_pkg::t_out got;
        if (!i_rst_n) begin
            regs.field_number    = dfe_pkg::RST_FIELD_NUMBER;
            regs.delimiter_chars = dfe_pkg::RST_DELIMITER_CHARS;
            regs.delimiter_count = dfe_pkg::RST_DELIMITER_COUNT;
            phase   = SCAN_SEEK;
            runs    = 8'd0;
            in_run  = 1'b0;
            emitted = 1'b0;
            field_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dfe_pkg::CFG_FIELD_NUMBER:
                        regs.field_number = i_cfg_wdata[7:0];
                    dfe_pkg::CFG_DELIMITER_CHARS:
                        regs.delimiter_chars = i_cfg_wdata;
                    dfe_pkg::CFG_DELIMITER_COUNT:
                        regs.delimiter_count = i_cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) scan_char(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (field_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction: char %02h valid %0b done %0b found %0b",
                                 got.field_char, got.char_valid, got.line_done,
                                 got.field_found);
                end else begin
                    want = field_q.pop_front();
                    if (got.field_char !== want.field_char ||
                        got.char_valid !== want.char_valid ||
                        got.line_done !== want.line_done ||
                        got.field_found !== want.field_found)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp char %02h valid %0b done %0b found %0b,",
                                      " got char %02h valid %0b done %0b found %0b"},
                                     want.field_char, want.char_valid, want.line_done,
                                     want.field_found, got.field_char, got.char_valid,
                                     got.line_done, got.field_found);
                    end
                end
            end
        end
        o_errors  <= errors;
        o_pending <= field_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the delimited field extractor: a directed set of lines over
// the special cases, then random lines under many delimiter settings, with
// bursty input, random output stall and a cycle limit.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1800;
    localparam logic [dfe_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [dfe_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [dfe_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                            i_valid     = 1'b0;
    dfe_pkg::t_in                    i_data      = '0;
    logic                            i_stall     = 1'b0;
    logic                            o_stall;
    logic                            o_valid;
    dfe_pkg::t_out                   o_data;

    int errors;
    int pending;
    int cycles     = 0;
    int chars_sent = 0;
    int burst_left = 0;

    logic [7:0]  sel_field = dfe_pkg::RST_FIELD_NUMBER;
    logic [63:0] sep_bytes = dfe_pkg::RST_DELIMITER_CHARS;
    logic [3:0]  sep_count = dfe_pkg::RST_DELIMITER_COUNT;

    always #5 i_clk = ~i_clk;

    delimited_field_extract dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

    dfe_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_valid),
        .i_in_data   (i_data),
        .i_in_stall  (o_stall),
        .i_out_valid (o_valid),
        .i_out_data  (o_data),
        .i_out_stall (i_stall),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // output stall, switching between patterns
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int k = 0; k < span; k++) begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ((k % 16) < 5);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [dfe_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic set_fields(input logic [7:0] fn, input logic [63:0] seps,
                              input logic [3:0] cnt);
        sel_field = fn;
        sep_bytes = seps;
        sep_count = cnt;
        write_reg(dfe_pkg::CFG_FIELD_NUMBER, {$urandom(), 24'($urandom()), fn});
        write_reg(dfe_pkg::CFG_DELIMITER_CHARS, seps);
        write_reg(dfe_pkg::CFG_DELIMITER_COUNT, {$urandom(), 28'($urandom()), cnt});
        write_reg(CFG_UNUSED, {$urandom(), $urandom()});
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_char(input logic [7:0] c, input logic l);
        dfe_pkg::t_in item;
        int           gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item.char_in = c;
        item.last    = l;
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
    endtask

    task automatic send_line(input logic [7:0] line[$]);
        for (int k = 0; k < line.size(); k++) send_char(line[k], k == line.size() - 1);
    endtask

    function automatic logic [7:0] pick_sep();
        int         n;
        int         k;
        logic [7:0] b;
        n = (sep_count > dfe_pkg::DELIM_LIMIT) ? dfe_pkg::DELIM_LIMIT : int'(sep_count);
        if (n == 0) return 8'($urandom_range(1, 255));
        k = $urandom_range(0, n - 1);
        b = sep_bytes[8*k +: 8];
        return (b == 8'd0) ? 8'($urandom_range(1, 255)) : b;
    endfunction

    task automatic send_random_line(input int max_fields);
        logic [7:0] line[$];
        int         nf;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 16)) line.push_back(8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) line.push_back(pick_sep());
            nf = $urandom_range(1, max_fields);
            for (int f = 0; f < nf; f++) begin
                if (f != 0) repeat ($urandom_range(1, 3)) line.push_back(pick_sep());
                repeat ($urandom_range(1, 5)) line.push_back(8'($urandom_range(1, 255)));
            end
            if ($urandom_range(0, 4) == 0) line.push_back(pick_sep());
        end
        send_line(line);
    endtask

    initial begin
        logic [7:0]  fn;
        logic [63:0] seps;
        logic [3:0]  cnt;
        int          start;
        int          lines;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: field 0, space delimiter
        send_text("ab cd");
        send_text(" x");
        drain();
        set_fields(8'd1, 64'h3B2C, 4'd2);
        send_text("a,;b");
        drain();
        set_fields(8'd3, 64'h3B2C, 4'd2);
        send_text("a,b");
        drain();
        set_fields(8'd0, 64'h2C, 4'd0);
        send_text("x,y");
        drain();
        // count saturates; zero byte and 0xff in the delimiter set
        set_fields(8'd1, 64'hFF00_0000_0000_0000, 4'd15);
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b1);
        drain();

        // highest field number reached in one long line
        start = chars_sent;
        set_fields(8'd255, 64'h2C, 4'd1);
        for (int k = 0; k < 255; k++) begin
            send_char(8'($urandom_range(1, 255)) | 8'h80, 1'b0);
            repeat ($urandom_range(1, 2)) send_char(8'h2C, 1'b0);
        end
        send_char(8'h7A, 1'b0);
        send_char(8'h79, 1'b1);
        drain();

        while (chars_sent - start < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                7, 8:    fn = 8'($urandom_range(5, 12));
                9:       fn = 8'd255;
                default: fn = 8'($urandom_range(0, 4));
            endcase
            case ($urandom_range(0, 4))
                0:       seps = {$urandom(), $urandom()};
                1:       seps = '1;
                2:       seps = '0;
                3:       seps = {$urandom(), $urandom()} & 64'hFF00_FF00_FFFF_00FF;
                default: seps = 64'h2D3A_2E7C_093B_2C20;
            endcase
            case ($urandom_range(0, 5))
                0:       cnt = 4'd0;
                1:       cnt = 4'($urandom_range(9, 15));
                2:       cnt = 4'd8;
                default: cnt = 4'($urandom_range(1, 8));
            endcase
            set_fields(fn, seps, cnt);
            lines = $urandom_range(10, 40);
            repeat (lines) begin
                if (chars_sent - start < ITEM_TARGET)
                    send_random_line((fn > 8'd12) ? 6 : int'(fn) + 3);
            end
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dfe_pkg.sv
rtl/core/dfe_cfg_regs.sv
rtl/core/dfe_delim_match.sv
rtl/core/dfe_tokenizer.sv
rtl/core/delimited_field_extract.sv
tb/dfe_checker.sv
tb/tb_top.sv
